FILE: sv/signed_integer_arith_unit_assert.svh
// Assertion macros used by the checker module of the arithmetic unit.
// Depends on nothing; included by the checker module.
`ifndef SIGNED_INTEGER_ARITH_UNIT_ASSERT_SVH
`define SIGNED_INTEGER_ARITH_UNIT_ASSERT_SVH
`define SIA_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("%m: label");
`define SIA_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("%m: label");
`endif

FILE: sv/sia_pkg.sv
// Package of the signed integer arithmetic unit: operation codes, the back part's
// state type and sizing constants. Depends on nothing.
package sia_pkg;
  localparam int DATA_WIDTH_DEF = 64;
  localparam int IO_WIDTH = 64;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
    OP_MOD = 3'd4, OP_REM = 3'd5, OP_POW = 3'd6, OP_BAD = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_DIV = 4'b0010, ST_MUL = 4'b0100, ST_POW = 4'b1000
  } state_t;
endpackage

FILE: sv/sia_front.sv
// Front part: accepts items, narrows operands and pushes them into a queue.
// Depends on sia_pkg.
module sia_front import sia_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       in_action,
  input  logic [IO_WIDTH-1:0] in_left_operand,
  input  logic [IO_WIDTH-1:0] in_right_operand,
  input  logic             pop,
  output logic             q_valid,
  output logic [2:0]       q_action,
  output logic [DW-1:0]    q_a,
  output logic [DW-1:0]    q_b
);
  logic [2:0]    act_r [QUEUE_DEPTH];
  logic [DW-1:0] a_r [QUEUE_DEPTH];
  logic [DW-1:0] b_r [QUEUE_DEPTH];
  logic          wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;

  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_action = act_r[rp_r];
  assign q_a = a_r[rp_r];
  assign q_b = b_r[rp_r];

  always_comb begin
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = (pop && q_valid) ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      act_r[wp_r] <= in_action;
      a_r[wp_r] <= in_left_operand[DW-1:0];
      b_r[wp_r] <= in_right_operand[DW-1:0];
    end
  end
endmodule

FILE: sv/sia_back.sv
// Back part: executes one queued item; divide iterates bit by bit, multiply and
// power use three-phase 32x32 multiplier units (one for multiply, two for power). Depends on sia_pkg.
module sia_mul import sia_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [DW-1:0] x,
  input  logic [DW-1:0] y,
  output logic          done,
  output logic [DW-1:0] p
);
  logic [63:0] x_r, y_r, lo_r, p_r, m;
  logic [31:0] mid_r, ma, mb;
  logic [2:0]  ph_r;
  logic        done_r;

  assign ma = ph_r[2] ? x_r[63:32] : x_r[31:0];
  assign mb = ph_r[1] ? y_r[63:32] : y_r[31:0];
  assign m = {32'd0, ma} * {32'd0, mb};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= '0;
      done_r <= 1'b0;
    end else begin
      ph_r <= {ph_r[1:0], go};
      done_r <= ph_r[2];
    end
    if (go) begin
      x_r <= 64'(x);
      y_r <= 64'(y);
    end
    if (ph_r[0]) lo_r <= m;
    if (ph_r[1]) mid_r <= lo_r[63:32] + m[31:0];
    if (ph_r[2]) p_r <= {mid_r + m[31:0], lo_r[31:0]};
  end

  assign done = done_r;
  assign p = p_r[DW-1:0];
endmodule

module sia_back import sia_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  logic [2:0]          q_action,
  input  logic [DW-1:0]       q_a,
  input  logic [DW-1:0]       q_b,
  output logic                pop,
  output logic                out_valid,
  output logic [IO_WIDTH-1:0] out_result_value,
  output logic                out_failed
);
  localparam int CW = $clog2(DW);
  state_t        st_r, st_nxt;
  logic [CW-1:0] cnt_r;
  logic [2:0]    op_r;
  logic [DW-1:0] a_r, b_r, rem_r, quo_r, acc_r, sq_r, exp_r;
  logic          an_r, bn_r;
  logic          ov_r;
  logic          wait_r;
  logic [DW-1:0] res_r;
  logic          fl_r;
  logic [DW-1:0] ua, ub, sum, dif, rs, rem_sh, rfin, qfin, rmod;
  logic [DW-1:0] m1_x, m1_p, m2_p;
  logic          m1_go, m2_go, m1_done, m2_done, mdone;
  logic          an, bn, done;
  logic [DW-1:0] res_nxt;
  logic          fl_nxt, ov_nxt;

  assign an = q_a[DW-1];
  assign bn = q_b[DW-1];
  assign ua = an ? -q_a : q_a;
  assign ub = bn ? -q_b : q_b;
  assign sum = q_a + q_b;
  assign dif = q_a - q_b;
  assign pop = q_valid && st_r == ST_IDLE;
  assign done = (cnt_r == CW'(DW - 1));
  assign rem_sh = {rem_r[DW-2:0], a_r[DW-1]};
  assign rs = (rem_sh >= b_r) ? rem_sh - b_r : rem_sh;
  assign qfin = {quo_r[DW-2:0], rem_sh >= b_r};
  assign rfin = an_r ? -rs : rs;
  assign rmod = (op_r == OP_MOD && rs != '0 && an_r != bn_r) ? rfin + (bn_r ? -b_r : b_r)
                                                              : rfin;

  assign m1_go = (st_r == ST_MUL || st_r == ST_POW) && !wait_r;
  assign m2_go = (st_r == ST_POW) && !wait_r;
  assign m1_x = (st_r == ST_MUL) ? exp_r : acc_r;
  assign mdone = m1_done && (m2_done || st_r == ST_MUL);

  sia_mul #(.DW(DW)) u_mul_acc (
    .clk, .rst_n, .go(m1_go), .x(m1_x), .y(sq_r), .done(m1_done), .p(m1_p)
  );

  sia_mul #(.DW(DW)) u_mul_sq (
    .clk, .rst_n, .go(m2_go), .x(sq_r), .y(sq_r), .done(m2_done), .p(m2_p)
  );

  always_comb begin
    st_nxt = st_r;
    ov_nxt = 1'b0;
    res_nxt = res_r;
    fl_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          ov_nxt = 1'b1;
          case (q_action)
            OP_ADD: res_nxt = sum;
            OP_SUB: res_nxt = dif;
            OP_MUL: begin
              ov_nxt = 1'b0;
              st_nxt = ST_MUL;
            end
            OP_DIV, OP_MOD, OP_REM: begin
              if (q_b == '0) begin
                res_nxt = '0;
                fl_nxt = 1'b1;
              end else begin
                ov_nxt = 1'b0;
                st_nxt = ST_DIV;
              end
            end
            OP_POW: begin
              if (bn) begin
                if (q_a == DW'(1)) res_nxt = DW'(1);
                else if (q_a == '1) res_nxt = q_b[0] ? '1 : DW'(1);
                else begin
                  res_nxt = '0;
                  fl_nxt = (q_a == '0);
                end
              end else begin
                ov_nxt = 1'b0;
                st_nxt = ST_POW;
              end
            end
            default: begin
              res_nxt = '0;
              fl_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (done) begin
          st_nxt = ST_IDLE;
          ov_nxt = 1'b1;
          res_nxt = (op_r == OP_DIV) ? ((an_r != bn_r) ? -qfin : qfin) : rmod;
        end
      end
      ST_MUL: begin
        if (mdone) begin
          st_nxt = ST_IDLE;
          ov_nxt = 1'b1;
          res_nxt = m1_p;
        end
      end
      ST_POW: begin
        if (mdone && done) begin
          st_nxt = ST_IDLE;
          ov_nxt = 1'b1;
          res_nxt = exp_r[0] ? m1_p : acc_r;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    res_r <= res_nxt;
    fl_r <= fl_nxt;
    if (st_r == ST_IDLE) begin
      cnt_r <= '0;
      wait_r <= 1'b0;
      op_r <= q_action;
      an_r <= an;
      bn_r <= bn;
      a_r <= ua;
      b_r <= ub;
      rem_r <= '0;
      quo_r <= '0;
      acc_r <= DW'(1);
      sq_r <= q_a;
      exp_r <= q_b;
    end else if (st_r == ST_DIV) begin
      cnt_r <= cnt_r + CW'(1);
      rem_r <= rs;
      quo_r <= qfin;
      a_r <= {a_r[DW-2:0], 1'b0};
    end else begin
      if (mdone) begin
        wait_r <= 1'b0;
        cnt_r <= cnt_r + CW'(1);
        if (exp_r[0]) acc_r <= m1_p;
        sq_r <= m2_p;
        exp_r <= exp_r >> 1;
      end else if (m1_go) begin
        wait_r <= 1'b1;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_result_value = IO_WIDTH'(signed'(res_r));
  assign out_failed = fl_r;
endmodule

FILE: sv/signed_integer_arith_unit.sv
// Signed integer arithmetic unit, top level. Add, sub, zero divisor, negative exponent and
// unused code finish in the back part's idle state, one item per cycle unless a longer item holds it.
// Mul uses the three-phase 32x32 multiplier in the back part; div, mod and rem use a bit-serial
// divide; power takes one exponent bit per multiplier pass. The back part takes a queued item
// only when it is through with the last one.
// Busy only when the 2-entry queue is full; the receiver cannot stall; sync reset empties all.
module signed_integer_arith_unit import sia_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_action,
  input  logic [IO_WIDTH-1:0] in_left_operand,
  input  logic [IO_WIDTH-1:0] in_right_operand,
  output logic                out_valid,
  output logic [IO_WIDTH-1:0] out_result_value,
  output logic                out_failed
);
  logic                  pop, q_valid;
  logic [2:0]            q_action;
  logic [DATA_WIDTH-1:0] q_a, q_b;

  sia_front #(.DW(DATA_WIDTH)) u_front (
    .clk, .rst_n, .start, .busy, .in_action, .in_left_operand, .in_right_operand,
    .pop, .q_valid, .q_action, .q_a, .q_b
  );

  sia_back #(.DW(DATA_WIDTH)) u_back (
    .clk, .rst_n, .q_valid, .q_action, .q_a, .q_b, .pop,
    .out_valid, .out_result_value, .out_failed
  );
endmodule

FILE: sv/sia_checker.sv
// Port-level checker of the arithmetic unit and its bind to the top level.
// Depends on signed_integer_arith_unit_assert.svh.
`include "signed_integer_arith_unit_assert.svh"
module sia_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic [63:0] out_result_value,
  input logic        out_failed
);
  `SIA_ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid && out_failed, out_result_value == 64'd0)
  `SIA_ASSERT_NEXT(a_rst_idle, clk, 1'b1, !rst_n, !out_valid && !busy)
  `SIA_ASSERT_IMPL(a_fail_only_valid, clk, rst_n, !out_valid, !out_failed)
endmodule

bind signed_integer_arith_unit sia_checker u_sia_checker (
  .clk, .rst_n, .busy, .out_valid, .out_result_value, .out_failed
);

FILE: tb/signed_integer_arith_unit_tb.sv
// Self-checking testbench of the signed integer arithmetic unit.
// Drives directed and random operations, predicts each result and compares them in order.
// Depends on sia_pkg and signed_integer_arith_unit.
module signed_integer_arith_unit_tb;
  import sia_pkg::*;

  localparam int DW = 64;
  localparam longint unsigned MAXCYC = 4000000;
  localparam logic [63:0] MINV = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAXV = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] left;
    logic [63:0] right;
  } op_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic        failed;
  } arith_res_t;

  logic clk, rst_n, start, busy, out_valid, out_failed;
  logic [2:0] in_action;
  logic [63:0] in_left_operand, in_right_operand, out_result_value;

  op_item_t   pending_ops[$];
  arith_res_t expected_results[$];
  int errors = 0;
  int transfers = 0;
  int results_seen = 0;
  longint unsigned cycles = 0;
  bit stim_done = 0;
  bit quiet = 0;
  bit taken = 0;

  signed_integer_arith_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_left_operand(in_left_operand),
    .in_right_operand(in_right_operand), .out_valid(out_valid),
    .out_result_value(out_result_value), .out_failed(out_failed)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] abs64(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic arith_res_t compute_arith(op_item_t it);
    arith_res_t r;
    logic [63:0] a, b, ua, ub, q, acc, sq;
    r.value = '0;
    r.failed = 0;
    a = it.left;
    b = it.right;
    ua = abs64(a);
    ub = abs64(b);
    case (it.action)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: r.value = a * b;
      OP_DIV: begin
        if (ub == 0) r.failed = 1;
        else begin
          q = ua / ub;
          r.value = (a[63] != b[63]) ? -q : q;
        end
      end
      OP_MOD, OP_REM: begin
        if (ub == 0) r.failed = 1;
        else begin
          q = ua % ub;
          if (a[63]) q = -q;
          if (it.action == OP_MOD && q != 0 && a[63] != b[63]) q = q + b;
          r.value = q;
        end
      end
      OP_POW: begin
        if (b[63]) begin
          if (a == 1) r.value = 1;
          else if (a == ONES) r.value = b[0] ? ONES : 64'd1;
          else if (a == 0) r.failed = 1;
          else r.value = 0;
        end else begin
          acc = 1;
          sq = a;
          for (int i = 0; i < DW; i++) begin
            if (b[i]) acc = acc * sq;
            sq = sq * sq;
          end
          r.value = acc;
        end
      end
      default: r.failed = 1;
    endcase
    if (r.failed) r.value = '0;
    return r;
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: v = MINV;
      1: v = MAXV;
      2: v = ONES;
      3: v = 0;
      4: v = 1;
      5: v = 64'(signed'($urandom_range(0, 40)) - 20);
      6: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic add_op(logic [2:0] act, logic [63:0] l, logic [63:0] r);
    op_item_t it;
    it.action = act;
    it.left = l;
    it.right = r;
    pending_ops.push_back(it);
  endtask

  initial begin
    logic [2:0] act;
    logic [63:0] l, r;
    add_op(OP_ADD, MAXV, 1);
    add_op(OP_ADD, MINV, ONES);
    add_op(OP_SUB, MINV, 1);
    add_op(OP_SUB, 0, MINV);
    add_op(OP_MUL, MAXV, MAXV);
    add_op(OP_MUL, MINV, ONES);
    add_op(OP_DIV, 7, 0);
    add_op(OP_DIV, MINV, ONES);
    add_op(OP_DIV, -64'sd7, 2);
    add_op(OP_MOD, -64'sd7, 2);
    add_op(OP_MOD, 7, -64'sd2);
    add_op(OP_MOD, 5, 0);
    add_op(OP_MOD, MINV, ONES);
    add_op(OP_REM, -64'sd7, 2);
    add_op(OP_REM, 3, 0);
    add_op(OP_REM, MINV, ONES);
    add_op(OP_POW, 1, ONES);
    add_op(OP_POW, ONES, -64'sd3);
    add_op(OP_POW, ONES, -64'sd4);
    add_op(OP_POW, 0, ONES);
    add_op(OP_POW, 5, MINV);
    add_op(OP_POW, 0, 0);
    add_op(OP_POW, 3, 40);
    add_op(OP_POW, MAXV, MAXV);
    add_op(OP_BAD, MAXV, MINV);
    for (int n = 0; n < 1800; n++) begin
      act = (n % 50 == 0) ? OP_BAD : 3'($urandom_range(0, 6));
      l = rand_operand();
      r = rand_operand();
      if (act == OP_POW && $urandom_range(0, 2) == 0) r = $urandom_range(0, 70);
      add_op(act, l, r);
    end
    stim_done = 1;
  end

  always @(negedge clk) begin
    cycles <= cycles + 1;
    if (cycles < 5) begin
      rst_n <= 0;
      start <= 0;
      in_action <= '0;
      in_left_operand <= '0;
      in_right_operand <= '0;
    end else begin
      rst_n <= 1;
      quiet <= (cycles > 8000 && cycles < 12000);
      if (taken) begin
        void'(pending_ops.pop_front());
      end
      if (start && !taken) begin
        // hold until transfer
      end else if (pending_ops.size() > 0 && (quiet || $urandom_range(0, 99) >= 11)) begin
        start <= 1;
        in_action <= pending_ops[0].action;
        in_left_operand <= pending_ops[0].left;
        in_right_operand <= pending_ops[0].right;
      end else begin
        start <= 0;
      end
    end
  end

  always @(posedge clk) begin
    op_item_t it;
    arith_res_t ex;
    taken = rst_n && start && !busy;
    if (rst_n) begin
      if (start && !busy) begin
        it.action = in_action;
        it.left = in_left_operand;
        it.right = in_right_operand;
        expected_results.push_back(compute_arith(it));
        transfers++;
      end
      if (out_valid) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result value=%h failed=%b", $time,
                   out_result_value, out_failed);
        end else begin
          ex = expected_results.pop_front();
          if (out_result_value !== ex.value) begin
            errors++;
            $display("%0t: value expected %h actual %h", $time, ex.value,
                     out_result_value);
          end
          if (out_failed !== ex.failed) begin
            errors++;
            $display("%0t: failed expected %b actual %b", $time, ex.failed, out_failed);
          end
        end
      end
    end
  end

  initial begin
    rst_n = 0;
    start = 0;
    in_action = '0;
    in_left_operand = '0;
    in_right_operand = '0;
    fork
      begin
        wait (stim_done && pending_ops.size() == 0 && !start);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge clk);
        $display("Ran %0d operations over all seven codes plus the unused one, %0d results",
                 transfers, results_seen);
        if (errors == 0 && expected_results.size() == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
      end
      begin
        wait (cycles >= MAXCYC);
        $display("Timeout after %0d cycles", cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    join
  end
endmodule
